// ----- rtl/sfa_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sfa_pkg - shared types and constants of the six-axis event frame assembler
// Event codes, result kinds, group codes, field widths and beat structures.
// ============================================================================
package sfa_pkg;

   localparam int AXIS_COUNT  = 6;
   localparam int GROUP_SIZE  = 3;
   localparam int AXIS_W      = 17;
   localparam int AXIS_IDX_W  = 3;
   localparam int TYPE_W      = 5;
   localparam int CODE_W      = 10;
   localparam int VALUE_W     = 16;
   localparam int TIME_W      = 32;
   localparam int KIND_W      = 2;
   localparam int DZ_W        = 15;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int GROUP_W     = 2;

   // event types
   localparam logic [TYPE_W-1:0] EV_SYNC = 5'd0;
   localparam logic [TYPE_W-1:0] EV_KEY  = 5'd1;
   localparam logic [TYPE_W-1:0] EV_REL  = 5'd2;
   localparam logic [TYPE_W-1:0] EV_ABS  = 5'd3;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MOTION  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd3;

   // last group codes
   localparam logic [GROUP_W-1:0] GROUP_NONE  = 2'd0;
   localparam logic [GROUP_W-1:0] GROUP_TRANS = 2'd1;
   localparam logic [GROUP_W-1:0] GROUP_ROT   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_ZONE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_TX = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_RZ = 3'd6;

   typedef logic signed [AXIS_W-1:0]  axis_value_type;
   typedef logic signed [VALUE_W-1:0] offset_type;

   typedef struct packed {
      logic [TYPE_W-1:0]         ev_type;
      logic [CODE_W-1:0]         ev_code;
      logic signed [VALUE_W-1:0] ev_value;
      logic [TIME_W-1:0]         ev_time;
   } event_item_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CODE_W-1:0] code;
      logic [TIME_W-1:0] stamp;
   } result_head_type;

endpackage

// ----- rtl/sfa_axis_cond.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sfa_axis_cond - axis conditioning
// Removes the rest offset, then trims the dead zone from the magnitude.
// ============================================================================
module sfa_axis_cond
   import sfa_pkg::*;
(
   input  logic signed [VALUE_W-1:0] raw_value,
   input  offset_type                offset,
   input  logic [DZ_W-1:0]           dead_zone,
   output axis_value_type            cond_value
);

   logic signed [AXIS_W:0] diff;
   logic signed [AXIS_W:0] dz_ext;
   logic signed [AXIS_W:0] trimmed;

   always_comb begin
      diff    = (AXIS_W+1)'(raw_value) - (AXIS_W+1)'(offset);
      dz_ext  = $signed({3'b000, dead_zone});
      if (diff >= 0) begin
         trimmed = diff - dz_ext;
         if (trimmed < 0) trimmed = '0;
      end else begin
         trimmed = diff + dz_ext;
         if (trimmed > 0) trimmed = '0;
      end
      cond_value = trimmed[AXIS_W-1:0];
   end

endmodule

// ----- rtl/sfa_frame_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sfa_frame_core - frame state and result register
// Holds the axis store, masks and last group; registers one result per non-axis beat.
// ============================================================================
module sfa_frame_core
   import sfa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  event_item_type        item,
   output logic                  advance,
   input  logic [DZ_W-1:0]       dead_zone,
   input  offset_type            offsets [AXIS_COUNT],
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output result_head_type       rsp_head,
   output axis_value_type        rsp_axes [AXIS_COUNT]
);

   axis_value_type              store_ff [AXIS_COUNT];
   axis_value_type              store_in [AXIS_COUNT];
   logic [AXIS_COUNT-1:0]       changed_ff, changed_in;
   logic [AXIS_COUNT-1:0]       received_ff, received_in;
   logic [GROUP_W-1:0]          group_ff, group_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   result_head_type             head_ff, head_in;
   axis_value_type              axes_ff [AXIS_COUNT];

   logic                        axis_hit;
   logic [AXIS_IDX_W-1:0]       axis_idx;
   offset_type                  sel_offset;
   axis_value_type              cond_value;
   logic                        produce;

   assign axis_idx   = item.ev_code[AXIS_IDX_W-1:0];
   assign axis_hit   = (item.ev_code < CODE_W'(AXIS_COUNT));
   assign sel_offset = axis_hit ? offsets[axis_idx] : '0;

   sfa_axis_cond u_cond (
      .raw_value  (item.ev_value),
      .offset     (sel_offset),
      .dead_zone  (dead_zone),
      .cond_value (cond_value)
   );

   // stall only when a result is parked and not taken
   assign advance = item_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      store_in    = store_ff;
      changed_in  = changed_ff;
      received_in = received_ff;
      group_in    = group_ff;
      produce     = 1'b1;
      head_in     = '0;
      if (item.ev_type == EV_REL || item.ev_type == EV_ABS) begin
         produce = 1'b0;
         if (axis_hit) begin
            store_in[axis_idx]    = cond_value;
            received_in[axis_idx] = 1'b1;
            if (cond_value != '0) changed_in[axis_idx] = 1'b1;
         end
      end else if (item.ev_type == EV_KEY) begin
         head_in.kind  = (item.ev_value != '0) ? KIND_PRESS : KIND_RELEASE;
         head_in.code  = item.ev_code;
         head_in.stamp = item.ev_time;
      end else if (item.ev_type == EV_SYNC) begin
         head_in.kind  = (changed_ff != '0) ? KIND_MOTION : KIND_NONE;
         head_in.code  = CODE_W'(changed_ff);
         head_in.stamp = item.ev_time;
         priority if (received_ff[GROUP_SIZE-1:0] != '0) begin
            group_in = GROUP_TRANS;
         end else if (received_ff[AXIS_COUNT-1:GROUP_SIZE] != '0) begin
            group_in = GROUP_ROT;
         end else if (group_ff == GROUP_TRANS) begin
            for (int i = GROUP_SIZE; i < AXIS_COUNT; i++) store_in[i] = '0;
            group_in = GROUP_ROT;
         end else if (group_ff == GROUP_ROT) begin
            for (int i = 0; i < GROUP_SIZE; i++) store_in[i] = '0;
            group_in = GROUP_TRANS;
         end else begin
            // no group seen yet: nothing to zero
            group_in = group_ff;
         end
      end
      // other types: none result, zero code and time
      if (produce) begin
         changed_in  = '0;
         received_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (!rsp_valid_ff || rsp_ready) rsp_valid_in = advance && produce;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXIS_COUNT; i++) store_ff[i] <= '0;
         changed_ff   <= '0;
         received_ff  <= '0;
         group_ff     <= GROUP_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            store_ff    <= store_in;
            changed_ff  <= changed_in;
            received_ff <= received_in;
            group_ff    <= group_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && produce) begin
         head_ff <= head_in;
         axes_ff <= store_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_head  = head_ff;
   assign rsp_axes  = axes_ff;

endmodule

// ----- rtl/six_axis_event_frame_assembler_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// six_axis_event_frame_assembler_top - six-axis event frame assembler
// Turns raw input event beats into key, motion and none result beats.
// ============================================================================
// Takes one event beat per clock. Each beat lands in an input register and
// then passes through the offset/dead-zone path and frame state into the
// result register; the block sustains one event per cycle and pauses only
// while a parked result waits for rsp_tready. Axis events (relative or
// absolute, axis 0..5) update the stored axis and the received/changed
// masks and give no result; axis numbers above five are dropped. Key events
// give press or release, sync gives motion (any axis changed) or none, and
// other types a none result with zero code and time. A sync with no axis
// received zeroes the opposite group of the one seen last. Every result
// carries all six stored axes. The user must write registers via csr_we
// only while idle; the block does not enforce it. Index 0 dead zone, 1..6
// offsets tx, ty, tz, rx, ry, rz; index 7 ignored.
// ============================================================================
module six_axis_event_frame_assembler_top
   import sfa_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // input events
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [63:0]             req_tdata,  // event_code[9:0], event_value[25:10],
                                               // event_time[57:26], zero pad
   input  logic [TYPE_W-1:0]       req_tuser,  // event_type[4:0]
   // results
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [143:0]            rsp_tdata,  // result_code[9:0], axis_tx[26:10],
                                               // axis_ty[43:27], axis_tz[60:44],
                                               // axis_rx[77:61], axis_ry[94:78],
                                               // axis_rz[111:95], result_time[143:112]
   output logic [KIND_W-1:0]       rsp_tuser,  // result_kind[1:0]
   // configuration
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   // config registers
   logic [DZ_W-1:0]   dead_zone_ff;
   offset_type        offset_ff [AXIS_COUNT];

   // input register
   logic              in_valid_ff, in_valid_in;
   event_item_type    in_item_ff;
   logic              advance;

   result_head_type   head;
   axis_value_type    axes [AXIS_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff <= '0;
         for (int i = 0; i < AXIS_COUNT; i++) offset_ff[i] <= '0;
      end else if (csr_we) begin
         if (csr_index == CSR_DEAD_ZONE) begin
            dead_zone_ff <= csr_wdata[DZ_W-1:0];
         end else if (csr_index >= CSR_OFFSET_TX && csr_index <= CSR_OFFSET_RZ) begin
            offset_ff[csr_index - CSR_OFFSET_TX] <= csr_wdata;
         end
      end
   end

   // input stage refills in the same cycle it drains
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) in_valid_in = req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.ev_type  <= req_tuser;
         in_item_ff.ev_code  <= req_tdata[9:0];
         in_item_ff.ev_value <= req_tdata[25:10];
         in_item_ff.ev_time  <= req_tdata[57:26];
      end
   end

   sfa_frame_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (in_valid_ff),
      .item       (in_item_ff),
      .advance    (advance),
      .dead_zone  (dead_zone_ff),
      .offsets    (offset_ff),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_head   (head),
      .rsp_axes   (axes)
   );

   // pack result beat
   assign rsp_tuser = head.kind;
   assign rsp_tdata = {head.stamp, axes[5], axes[4], axes[3],
                       axes[2], axes[1], axes[0], head.code};

endmodule

// ----- bench/tb_six_axis_event_frame_assembler_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_six_axis_event_frame_assembler_top - self-checking bench for the assembler
// Drives event beats with random gaps and checks every result beat, field by
// field, against a frame predictor kept in a small scoreboard class.
// ============================================================================
import sfa_pkg::*;

// One result beat, split into its fields.
typedef struct packed {
   logic [KIND_W-1:0]                  kind;
   logic [CODE_W-1:0]                  code;
   logic [AXIS_COUNT-1:0][AXIS_W-1:0]  axes;
   logic [TIME_W-1:0]                  stamp;
} frame_result_type;

// Frame predictor plus the queue of result beats it expects.
class frame_scoreboard;
   logic [DZ_W-1:0]    dead_zone;
   offset_type         rest_offset [AXIS_COUNT];
   axis_value_type     axis_store [AXIS_COUNT];
   logic [AXIS_COUNT-1:0] changed;
   logic [AXIS_COUNT-1:0] received;
   logic [GROUP_W-1:0] last_group;
   frame_result_type   expected_frames [$];
   int                 mismatches;

   function new();
      dead_zone  = '0;
      changed    = '0;
      received   = '0;
      last_group = GROUP_NONE;
      mismatches = 0;
      for (int i = 0; i < AXIS_COUNT; i++) begin
         rest_offset[i] = '0;
         axis_store[i]  = '0;
      end
   endfunction

   function void write_reg(input logic [CSR_IDX_W-1:0] idx,
                           input logic [CSR_DATA_W-1:0] data);
      if (idx == CSR_DEAD_ZONE)
         dead_zone = data[DZ_W-1:0];
      else if (idx >= CSR_OFFSET_TX && idx <= CSR_OFFSET_RZ)
         rest_offset[idx - CSR_OFFSET_TX] = data;
   endfunction

   function int pending();
      return expected_frames.size();
   endfunction

   // every result carries the full axis store and closes the frame
   function void close_frame(input logic [KIND_W-1:0] kind,
                             input logic [CODE_W-1:0] code,
                             input logic [TIME_W-1:0] stamp);
      frame_result_type r;
      r.kind  = kind;
      r.code  = code;
      r.stamp = stamp;
      for (int i = 0; i < AXIS_COUNT; i++)
         r.axes[i] = axis_store[i];
      expected_frames.push_back(r);
      changed  = '0;
      received = '0;
   endfunction

   function void note_event(input event_item_type ev);
      int v;
      int dz;
      int idx;
      dz = int'(dead_zone);
      case (ev.ev_type)
         EV_REL, EV_ABS: begin
            if (ev.ev_code >= AXIS_COUNT)
               return;
            idx = int'(ev.ev_code);
            v = int'($signed(ev.ev_value)) - int'($signed(rest_offset[idx]));
            if (v >= 0) begin
               v = v - dz;
               if (v < 0) v = 0;
            end else begin
               v = v + dz;
               if (v > 0) v = 0;
            end
            axis_store[idx] = axis_value_type'(v);
            received[idx] = 1'b1;
            if (v != 0)
               changed[idx] = 1'b1;
         end
         EV_KEY: begin
            close_frame((ev.ev_value != 0) ? KIND_PRESS : KIND_RELEASE,
                        ev.ev_code, ev.ev_time);
         end
         EV_SYNC: begin
            logic [AXIS_COUNT-1:0] cmask;
            cmask = changed;
            if (received[GROUP_SIZE-1:0] != 0) begin
               last_group = GROUP_TRANS;
            end else if (received[AXIS_COUNT-1:GROUP_SIZE] != 0) begin
               last_group = GROUP_ROT;
            end else if (last_group == GROUP_TRANS) begin
               // empty frame after translation: rotation has gone quiet
               for (int i = GROUP_SIZE; i < AXIS_COUNT; i++) axis_store[i] = '0;
               last_group = GROUP_ROT;
            end else if (last_group == GROUP_ROT) begin
               for (int i = 0; i < GROUP_SIZE; i++) axis_store[i] = '0;
               last_group = GROUP_TRANS;
            end
            close_frame((cmask != 0) ? KIND_MOTION : KIND_NONE,
                        CODE_W'(cmask), ev.ev_time);
         end
         default: close_frame(KIND_NONE, '0, '0);
      endcase
   endfunction

   function void flag(input string what, input longint want, input longint got);
      mismatches++;
      if (mismatches <= 10)
         $display("%t mismatch %s: expected %0h, got %0h", $realtime, what, want, got);
   endfunction

   function void check_result(input frame_result_type got);
      frame_result_type want;
      if (expected_frames.size() == 0) begin
         flag("unexpected result beat, kind", 0, got.kind);
         return;
      end
      want = expected_frames.pop_front();
      if (got.kind !== want.kind)   flag("result_kind", want.kind, got.kind);
      if (got.code !== want.code)   flag("result_code", want.code, got.code);
      for (int i = 0; i < AXIS_COUNT; i++)
         if (got.axes[i] !== want.axes[i])
            flag($sformatf("axis %0d", i), want.axes[i], got.axes[i]);
      if (got.stamp !== want.stamp) flag("result_time", want.stamp, got.stamp);
   endfunction
endclass

module tb_six_axis_event_frame_assembler_top;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;   // unused index, ignored
   localparam logic [TYPE_W-1:0] EV_OTHER_LO = 5'd4;
   localparam logic [TYPE_W-1:0] EV_OTHER_HI = 5'd31;
   localparam int SETTLE_CYCLES = 8;     // extra wait for axis beats still in flight
   localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
   localparam int QUIET_LIMIT   = 5000;  // cycles without any beat before giving up

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [63:0]           req_tdata = '0;
   logic [TYPE_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [143:0]          rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   frame_scoreboard sb = new();

   // current register values, used to aim axis values at the dead-zone edges
   int  cur_dz;
   int  cur_off [AXIS_COUNT];
   bit  send_gaps;
   bit  recv_gaps;
   logic hold_req = 1'b0;
   int  hold_left = 0;
   int  quiet = 0;
   frame_result_type seen;

   six_axis_event_frame_assembler_top dut (.*);

   always #6 clock = ~clock;

   // result side: check accepted beats, then pick tready for the next edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.kind  = rsp_tuser;
         seen.code  = rsp_tdata[CODE_W-1:0];
         for (int i = 0; i < AXIS_COUNT; i++)
            seen.axes[i] = rsp_tdata[CODE_W + AXIS_W*i +: AXIS_W];
         seen.stamp = rsp_tdata[143:112];
         sb.check_result(seen);
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_req) begin
         // long hold-off: sender keeps offering so the block backs up
         hold_left = HOLD_CYCLES;
         hold_req <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(recv_gaps && $urandom_range(99) < 22);
      end
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_event(input logic [TYPE_W-1:0] ev_type,
                             input logic [CODE_W-1:0] code,
                             input logic [VALUE_W-1:0] value,
                             input logic [TIME_W-1:0] stamp);
      event_item_type ev;
      ev.ev_type  = ev_type;
      ev.ev_code  = code;
      ev.ev_value = value;
      ev.ev_time  = stamp;
      while (send_gaps && $urandom_range(99) < 22) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= ev_type;
      req_tdata  <= {6'd0, stamp, value, code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_event(ev);
   endtask

   // idle the input, wait for every result, then for any axis beat in flight
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // writes all registers from cur_dz / cur_off, plus the ignored index
   task automatic load_registers();
      logic [CSR_DATA_W-1:0] data;
      for (int i = 0; i <= int'(CSR_SPARE); i++) begin
         if (i == 0)
            data = CSR_DATA_W'(cur_dz);
         else if (i <= AXIS_COUNT)
            data = CSR_DATA_W'(cur_off[i-1]);
         else
            data = CSR_DATA_W'($urandom);
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= data;
         sb.write_reg(CSR_IDX_W'(i), data);
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic axis_beat(input int axis);
      int v;
      logic [VALUE_W-1:0] val;
      if ($urandom_range(1)) begin
         val = VALUE_W'($urandom);
      end else begin
         // land near the dead-zone edge on either side of the rest offset
         v = cur_off[axis] + ($urandom_range(1) ? cur_dz : -cur_dz)
             + int'($urandom_range(0, 8)) - 4;
         val = VALUE_W'(v);
      end
      send_event($urandom_range(1) ? EV_REL : EV_ABS, CODE_W'(axis), val, $urandom);
   endtask

   // mostly well-formed frames (axis beats then sync), some keys and noise
   task automatic run_frames(input int count, input bit with_hold);
      int sent;
      int pick;
      int span;
      int lo;
      int hi;
      int ending;
      bit hold_sent;
      sent = 0;
      hold_sent = 1'b0;
      while (sent < count) begin
         if (with_hold && !hold_sent && sent >= count / 2) begin
            hold_req <= 1'b1;
            hold_sent = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 70) begin
            span = $urandom_range(0, 5);
            case ($urandom_range(3))
               0:       begin lo = 0;          hi = GROUP_SIZE - 1; end
               1:       begin lo = GROUP_SIZE; hi = AXIS_COUNT - 1; end
               default: begin lo = 0;          hi = AXIS_COUNT - 1; end
            endcase
            for (int k = 0; k < span; k++)
               axis_beat($urandom_range(lo, hi));
            ending = $urandom_range(99);
            if (ending < 80)
               send_event(EV_SYNC, CODE_W'($urandom), VALUE_W'($urandom), $urandom);
            else if (ending < 95)
               send_event(EV_KEY, CODE_W'($urandom_range(0, 767)),
                          $urandom_range(1) ? VALUE_W'(0) : VALUE_W'($urandom), $urandom);
            else
               send_event(TYPE_W'($urandom_range(EV_OTHER_LO, EV_OTHER_HI)),
                          CODE_W'($urandom), VALUE_W'($urandom), $urandom);
            sent = sent + span + 1;
         end else if (pick < 85) begin
            send_event(EV_KEY, CODE_W'($urandom_range(0, 767)),
                       $urandom_range(2) == 0 ? VALUE_W'(0) : VALUE_W'($urandom), $urandom);
            sent++;
         end else if (pick < 92) begin
            // axis number out of range: dropped, not counted
            send_event($urandom_range(1) ? EV_REL : EV_ABS,
                       CODE_W'($urandom_range(AXIS_COUNT, 767)), VALUE_W'($urandom), $urandom);
         end else begin
            send_event(TYPE_W'($urandom_range(0, 31)), CODE_W'($urandom_range(0, 767)),
                       VALUE_W'($urandom), $urandom);
            sent++;
         end
      end
      settle();
   endtask

   initial begin
      send_gaps = 1'b1;
      recv_gaps = 1'b1;
      cur_dz = 0;
      for (int i = 0; i < AXIS_COUNT; i++) cur_off[i] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reset registers, group tracking and field extremes
      send_event(EV_SYNC, '0, '0, '0);                     // empty frame, no group yet
      send_event(EV_ABS, CODE_W'(0), 16'sh7FFF, 32'hFFFF_FFFF);
      send_event(EV_REL, CODE_W'(5), 16'sh8000, 32'h0);
      send_event(EV_ABS, CODE_W'(6), 16'sh0001, 32'h1);     // axis above five
      send_event(EV_REL, CODE_W'(767), 16'shFFFF, 32'h2);
      send_event(EV_SYNC, CODE_W'(767), 16'sh7FFF, 32'hFFFF_FFFF);
      send_event(EV_SYNC, '0, '0, 32'h10);                 // zeroes rotation
      send_event(EV_SYNC, '0, '0, 32'h11);                 // zeroes translation
      send_event(EV_REL, CODE_W'(3), '0, 32'h12);          // received, not changed
      send_event(EV_SYNC, '0, '0, 32'h13);
      send_event(EV_ABS, CODE_W'(4), 16'sd100, 32'h14);
      send_event(EV_SYNC, '0, '0, 32'h15);
      send_event(EV_SYNC, '0, '0, 32'h16);
      send_event(EV_SYNC, '0, '0, 32'h17);
      send_event(EV_KEY, CODE_W'(767), 16'sd1, 32'h18);
      send_event(EV_KEY, CODE_W'(0), '0, 32'h19);
      send_event(EV_KEY, CODE_W'(1), 16'sh8000, 32'h1A);
      send_event(EV_ABS, CODE_W'(1), 16'sh1234, 32'h1B);
      send_event(EV_KEY, CODE_W'(2), '0, 32'h1C);          // key clears the masks
      send_event(EV_SYNC, '0, '0, 32'h1D);
      send_event(EV_OTHER_LO, CODE_W'(767), 16'sh7FFF, 32'hFFFF_FFFF);
      send_event(EV_OTHER_HI, CODE_W'(5), 16'sh8000, 32'h1E);
      settle();

      // widest dead zone, offsets at both extremes
      cur_dz = 32767;
      for (int i = 0; i < AXIS_COUNT; i++) cur_off[i] = (i % 2) ? 32767 : -32768;
      load_registers();
      run_frames(300, 1'b0);

      // no dead zone, offsets swapped; no gaps on either side
      send_gaps = 1'b0;
      recv_gaps = 1'b0;
      cur_dz = 0;
      for (int i = 0; i < AXIS_COUNT; i++) cur_off[i] = (i % 2) ? -32768 : 32767;
      load_registers();
      run_frames(300, 1'b0);

      // small dead zone, random offsets, with the long receiver hold-off
      send_gaps = 1'b1;
      recv_gaps = 1'b1;
      cur_dz = $urandom_range(0, 200);
      for (int i = 0; i < AXIS_COUNT; i++) cur_off[i] = int'($urandom_range(0, 65535)) - 32768;
      load_registers();
      run_frames(500, 1'b1);

      cur_dz = $urandom_range(0, 32767);
      for (int i = 0; i < AXIS_COUNT; i++) cur_off[i] = int'($urandom_range(0, 65535)) - 32768;
      load_registers();
      run_frames(400, 1'b0);

      cur_dz = $urandom_range(1, 2000);
      for (int i = 0; i < AXIS_COUNT; i++) cur_off[i] = 0;
      load_registers();
      run_frames(400, 1'b0);

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
